### sv/indexed_list_insert_erase_defines.svh
// Assertion macros shared by the list RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef INDEXED_LIST_INSERT_ERASE_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_DEFINES_SVH

// Plain property, checked on every clock edge out of reset
`define ILIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define ILIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ILIE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ilie_pkg.sv
package ilie_pkg;

  // Request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_RESIZE = 2'd3
  } req_e;

  // Result status carried in the output tuser
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_TOOBIG = 2'd3
  } status_e;

  // Operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_RESIZE = 2'd3
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_GATHER = 2'b10
  } state_e;

  // Fixed widths of the word fields
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned STAT_W = 2;

  // Cells per first-level read reduction group
  localparam int unsigned GRP_SIZE = 8;

endpackage

### sv/ilie_cell.sv
module ilie_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CMP_W      = 7,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  ilie_pkg::op_e         op_i,
  input  logic [CMP_W-1:0]      pos_i,
  input  logic [CMP_W-1:0]      cnt_i,
  input  logic [CMP_W-1:0]      nlen_i,
  input  logic [DATA_WIDTH-1:0] load_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam logic [CMP_W-1:0] IdxC  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] IdxP1 = CMP_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  // Pick this cell's next entry from its own index against the broadcast
  always_comb begin
    data_d = data_q;
    unique case (op_i)
      ilie_pkg::OP_INSERT: begin
        if (IdxC == pos_i) begin
          data_d = load_i;
        end else if ((IdxC > pos_i) && (IdxC <= cnt_i)) begin
          data_d = left_i;
        end
      end
      ilie_pkg::OP_ERASE: begin
        if ((IdxC >= pos_i) && (IdxP1 < cnt_i)) begin
          data_d = right_i;
        end
      end
      ilie_pkg::OP_RESIZE: begin
        if ((IdxC >= cnt_i) && (IdxC < nlen_i)) begin
          data_d = load_i;
        end
      end
      ilie_pkg::OP_NONE: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // Drive the entry onto the read tree only when addressed
  assign rd_o = (IdxC == pos_i) ? data_q : '0;

endmodule

### sv/indexed_list_insert_erase.sv
// Results: insert, erase and resize give their result word in the cycle after acceptance;
// a read goes through the registered first OR level over the cells, then the gather state.
// Throughput: 1 request per cycle for insert/erase/resize while the output is free or taken;
// a read holds off new requests in the gather state; all cells shift or load in parallel.
// Reset: asynchronous active low; clears state, length and the output valid, entries
// keep no reset value and are read only after being written.
`include "indexed_list_insert_erase_defines.svh"

module indexed_list_insert_erase #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] position, [38:7] value, [45:39] new_length, [47:46] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_value, [38:32] length, [39] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned CmpW   = (CntW > ilie_pkg::POS_W) ? CntW : ilie_pkg::POS_W;
  localparam int unsigned GrpSz  = ilie_pkg::GRP_SIZE;
  localparam int unsigned NumGrp = (DEPTH + GrpSz - 1) / GrpSz;
  localparam logic [CmpW-1:0] DepthC = CmpW'(DEPTH);

  // Input word fields
  ilie_pkg::req_e                 req;
  logic [ilie_pkg::POS_W-1:0]     pos_f;
  logic [ilie_pkg::VAL_W-1:0]     val_f;
  logic [ilie_pkg::LEN_W-1:0]     nlen_f;
  logic                           acc;

  assign req    = ilie_pkg::req_e'(s_axis_tuser);
  assign pos_f  = s_axis_tdata[6:0];
  assign val_f  = s_axis_tdata[38:7];
  assign nlen_f = s_axis_tdata[45:39];

  // Control state
  ilie_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic [ilie_pkg::VAL_W-1:0]  out_rd_q, out_rd_d;
  logic [ilie_pkg::STAT_W-1:0] out_st_q, out_st_d;
  logic [ilie_pkg::LEN_W-1:0]  out_len_q, out_len_d;
  logic             rd_ok_q, rd_ok_d;

  // Request evaluation
  logic [CmpW-1:0]       pos_x, cnt_x, nlen_x, cnt_next_x;
  ilie_pkg::status_e     st;
  ilie_pkg::op_e         op;
  logic [63:0]           val_ext;
  logic [DATA_WIDTH-1:0] val_dw;

  assign pos_x   = CmpW'(pos_f);
  assign cnt_x   = CmpW'(count_q);
  assign nlen_x  = CmpW'(nlen_f);
  assign val_ext = {32'b0, val_f};
  assign val_dw  = val_ext[DATA_WIDTH-1:0];

  assign s_axis_tready = (state_q == ilie_pkg::S_IDLE) && (!out_valid_q || m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Check the request against the length and choose the cell operation
  always_comb begin
    st         = ilie_pkg::ST_OK;
    op         = ilie_pkg::OP_NONE;
    cnt_next_x = cnt_x;
    unique case (req)
      ilie_pkg::REQ_INSERT: begin
        if (pos_x > cnt_x) begin
          st = ilie_pkg::ST_BADPOS;
        end else if (cnt_x >= DepthC) begin
          st = ilie_pkg::ST_FULL;
        end else begin
          op         = ilie_pkg::OP_INSERT;
          cnt_next_x = cnt_x + CmpW'(1);
        end
      end
      ilie_pkg::REQ_ERASE: begin
        if (pos_x >= cnt_x) begin
          st = ilie_pkg::ST_BADPOS;
        end else begin
          op         = ilie_pkg::OP_ERASE;
          cnt_next_x = cnt_x - CmpW'(1);
        end
      end
      ilie_pkg::REQ_READ: begin
        if (pos_x >= cnt_x) begin
          st = ilie_pkg::ST_BADPOS;
        end
      end
      ilie_pkg::REQ_RESIZE: begin
        if (nlen_x > DepthC) begin
          st = ilie_pkg::ST_TOOBIG;
        end else begin
          op         = ilie_pkg::OP_RESIZE;
          cnt_next_x = nlen_x;
        end
      end
    endcase
  end

  // Row of cells
  ilie_pkg::op_e         cell_op;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] rd_pad    [NumGrp*GrpSz];

  assign cell_op = acc ? op : ilie_pkg::OP_NONE;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    ilie_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CMP_W      (CmpW),
      .IDX        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .pos_i   (pos_x),
      .cnt_i   (cnt_x),
      .nlen_i  (nlen_x),
      .load_i  (val_dw),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .rd_o    (rd_pad[i])
    );
  end

  for (genvar i = DEPTH; i < NumGrp * GrpSz; i++) begin : g_pad
    assign rd_pad[i] = '0;
  end

  // First reduction level: OR each group of cells into a register
  logic [DATA_WIDTH-1:0] grp_d [NumGrp];
  logic [DATA_WIDTH-1:0] grp_q [NumGrp];
  logic [DATA_WIDTH-1:0] rd_or;

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GrpSz; k++) begin
        grp_d[g] = grp_d[g] | rd_pad[g*GrpSz + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  // Second reduction level over the group registers
  always_comb begin
    rd_or = '0;
    for (int g = 0; g < NumGrp; g++) begin
      rd_or = rd_or | grp_q[g];
    end
  end

  // Sign-extend the read entry to the 32-bit result field
  logic [63:0] rd_ext, rd_sx;

  assign rd_ext = 64'(rd_or);

  always_comb begin
    for (int k = 0; k < 64; k++) begin
      rd_sx[k] = (k < DATA_WIDTH) ? rd_ext[k] : rd_or[DATA_WIDTH-1];
    end
  end

  // Sequence requests and load the output register
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_rd_d    = out_rd_q;
    out_st_d    = out_st_q;
    out_len_d   = out_len_q;
    rd_ok_d     = rd_ok_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ilie_pkg::S_IDLE: begin
        if (acc) begin
          count_d = CntW'(cnt_next_x);
          if (req == ilie_pkg::REQ_READ) begin
            rd_ok_d  = (st == ilie_pkg::ST_OK);
            out_st_d = st;
            state_d  = ilie_pkg::S_GATHER;
          end else begin
            out_valid_d = 1'b1;
            out_rd_d    = '0;
            out_st_d    = st;
            out_len_d   = cnt_next_x[ilie_pkg::LEN_W-1:0];
          end
        end
      end
      ilie_pkg::S_GATHER: begin
        out_valid_d = 1'b1;
        out_rd_d    = rd_ok_q ? rd_sx[31:0] : '0;
        out_len_d   = cnt_x[ilie_pkg::LEN_W-1:0];
        state_d     = ilie_pkg::S_IDLE;
      end
      default: begin
        state_d = ilie_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ilie_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold result payload until loaded again
  always_ff @(posedge clk_i) begin
    out_rd_q  <= out_rd_d;
    out_st_q  <= out_st_d;
    out_len_q <= out_len_d;
    rd_ok_q   <= rd_ok_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_len_q, out_rd_q};
  assign m_axis_tuser  = out_st_q;

  `ILIE_ASSERT(a_count_range, CmpW'(count_q) <= DepthC, "list length above depth")
  `ILIE_ASSERT_IMP(a_gather_stall, state_q == ilie_pkg::S_GATHER, !s_axis_tready, "word taken during read gather")
  `ILIE_ASSERT_NXT(a_gather_once, state_q == ilie_pkg::S_GATHER, (state_q == ilie_pkg::S_IDLE) && m_axis_tvalid, "read gather did not finish")
  `ILIE_ASSERT_NXT(a_read_gather, acc && (req == ilie_pkg::REQ_READ), state_q == ilie_pkg::S_GATHER, "read did not enter gather")
  `ILIE_ASSERT_NXT(a_direct_result, acc && (req != ilie_pkg::REQ_READ), m_axis_tvalid && $stable(state_q), "missing result word")

endmodule
